// ===== sv/sbfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfd_pkg
// Types and constants shared by the S.BUS frame decoder modules.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int VALUE_BITS    = 11;
  localparam int BYTE_BITS     = 8;
  localparam int DATA_BYTES    = (CHANNEL_COUNT * VALUE_BITS) / BYTE_BITS;

  localparam logic [7:0] HEADER_BYTE  = 8'h0f;
  localparam int         FAILSAFE_BIT = 3;

  // frame position: 0 waits for header, 1..DATA_BYTES data, then flag, then end
  localparam logic [4:0] POS_IDLE     = 5'd0;
  localparam logic [4:0] POS_DATA_LST = 5'(DATA_BYTES);
  localparam logic [4:0] POS_FLAG     = 5'(DATA_BYTES + 1);
  localparam logic [4:0] POS_END      = 5'(DATA_BYTES + 2);

  localparam logic KIND_CHANNEL   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_FLAG = 2'd1,
    OP_END  = 2'd2
  } cmd_op_t;

  // one classified byte handed from front to back
  typedef struct packed {
    cmd_op_t    op;
    logic       first;   // first data byte of a frame
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== sv/sbfd_front.sv =====
// ----------------------------------------------------------------------------
// sbfd_front
// Tracks the byte position in the frame and turns each accepted byte into a
// command for the unpacker (data, flag or end), dropping bytes that do nothing.
// ----------------------------------------------------------------------------
module sbfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          q_full,
  input  logic [7:0]    in_received_byte,
  input  logic          in_line_error,
  output logic          q_push,
  output sbfd_pkg::cmd_t q_cmd
);

  logic [4:0] pos_r, pos_nxt;
  logic [4:0] pos_cur;
  logic       acc;

  assign acc     = in_push && !q_full;
  assign pos_cur = in_line_error ? sbfd_pkg::POS_IDLE : pos_r;

  always_comb begin
    pos_nxt     = pos_r;
    q_push      = 1'b0;
    q_cmd.op    = sbfd_pkg::OP_DATA;
    q_cmd.first = (pos_cur == 5'd1);
    q_cmd.data  = in_received_byte;
    if (acc) begin
      pos_nxt = pos_cur;
      priority if (pos_cur == sbfd_pkg::POS_IDLE) begin
        if (in_received_byte == sbfd_pkg::HEADER_BYTE) pos_nxt = 5'd1;
      end else if (pos_cur <= sbfd_pkg::POS_DATA_LST) begin
        q_push   = 1'b1;
        q_cmd.op = sbfd_pkg::OP_DATA;
        pos_nxt  = pos_cur + 5'd1;
      end else if (pos_cur == sbfd_pkg::POS_FLAG) begin
        q_push   = 1'b1;
        q_cmd.op = sbfd_pkg::OP_FLAG;
        pos_nxt  = sbfd_pkg::POS_END;
      end else begin
        // waiting for the end byte; nonzero bytes are dropped
        if (in_received_byte == 8'd0) begin
          q_push   = 1'b1;
          q_cmd.op = sbfd_pkg::OP_END;
          pos_nxt  = sbfd_pkg::POS_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= sbfd_pkg::POS_IDLE;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== sv/sbfd_queue.sv =====
// ----------------------------------------------------------------------------
// sbfd_queue
// Small command queue between the front end and the unpacker.
// ----------------------------------------------------------------------------
module sbfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbfd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output sbfd_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbfd_pkg::cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== sv/sbfd_back.sv =====
// ----------------------------------------------------------------------------
// sbfd_back
// Bit unpacker: merges data bytes into 11-bit channel values, latches the
// failsafe flag and builds frame-end results in the output register.
// ----------------------------------------------------------------------------
module sbfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  sbfd_pkg::cmd_t q_head,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output logic           out_result_kind,
  output logic [3:0]     out_channel_index,
  output logic [10:0]    out_channel_value,
  output logic           out_signal_valid
);

  logic [3:0]  pend_r, pend_nxt;
  logic [10:0] part_r, part_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        fs_r, fs_nxt;
  logic        ofull_r, ofull_nxt;
  logic        okind_r, okind_nxt;
  logic [3:0]  oidx_r, oidx_nxt;
  logic [10:0] oval_r, oval_nxt;
  logic        osv_r, osv_nxt;

  logic [3:0]  p;
  logic [10:0] part;
  logic [3:0]  cnt;
  logic [4:0]  total;
  logic [2:0]  r;
  logic [18:0] shifted;
  logic [10:0] merged;
  logic [7:0]  spill;
  logic        take;

  assign take    = q_valid && (!ofull_r || out_pop);
  assign q_pop   = take;

  assign p       = q_head.first ? 4'd0 : pend_r;
  assign part    = q_head.first ? 11'd0 : part_r;
  assign cnt     = q_head.first ? 4'd0 : cnt_r;
  assign total   = {1'b0, p} + 5'(sbfd_pkg::BYTE_BITS);
  assign r       = 3'(total - 5'(sbfd_pkg::VALUE_BITS));
  assign shifted = {11'd0, q_head.data} << p;
  assign merged  = part | shifted[10:0];
  assign spill   = q_head.data >> (4'(sbfd_pkg::BYTE_BITS) - {1'b0, r});

  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    cnt_nxt   = cnt_r;
    fs_nxt    = fs_r;
    ofull_nxt = ofull_r && !out_pop;
    okind_nxt = okind_r;
    oidx_nxt  = oidx_r;
    oval_nxt  = oval_r;
    osv_nxt   = osv_r;
    if (take) begin
      unique case (q_head.op)
        sbfd_pkg::OP_DATA: begin
          if (total >= 5'(sbfd_pkg::VALUE_BITS)) begin
            ofull_nxt = 1'b1;
            okind_nxt = sbfd_pkg::KIND_CHANNEL;
            oidx_nxt  = cnt;
            oval_nxt  = merged;
            osv_nxt   = 1'b0;
            cnt_nxt   = cnt + 4'd1;
            part_nxt  = {3'd0, spill};
            pend_nxt  = {1'b0, r};
          end else begin
            cnt_nxt   = cnt;
            part_nxt  = merged;
            pend_nxt  = total[3:0];
          end
        end
        sbfd_pkg::OP_FLAG: begin
          fs_nxt = q_head.data[sbfd_pkg::FAILSAFE_BIT];
        end
        sbfd_pkg::OP_END: begin
          ofull_nxt = 1'b1;
          okind_nxt = sbfd_pkg::KIND_FRAME_END;
          oidx_nxt  = 4'd0;
          oval_nxt  = 11'd0;
          osv_nxt   = !fs_r;
          pend_nxt  = 4'd0;
          part_nxt  = 11'd0;
          cnt_nxt   = 4'd0;
        end
        default: begin
          fs_nxt = fs_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 4'd0;
      part_r  <= 11'd0;
      cnt_r   <= 4'd0;
      fs_r    <= 1'b0;
      ofull_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      part_r  <= part_nxt;
      cnt_r   <= cnt_nxt;
      fs_r    <= fs_nxt;
      ofull_r <= ofull_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    oidx_r  <= oidx_nxt;
    oval_r  <= oval_nxt;
    osv_r   <= osv_nxt;
  end

  assign out_empty         = !ofull_r;
  assign out_result_kind   = okind_r;
  assign out_channel_index = oidx_r;
  assign out_channel_value = oval_r;
  assign out_signal_valid  = osv_r;

endmodule

// ===== sv/sbus_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// S.BUS receiver frame decoder: UART bytes in, channel values and frame-end
// status out.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle (push/full) and returns results through
// a queue-style port (empty/pop). After a 0x0f header, the 22 data bytes are
// unpacked LSB first into sixteen 11-bit channels; each channel comes out as
// soon as its last bit arrives. Bit 3 of the next byte is the failsafe flag;
// then nonzero bytes are dropped and a zero byte yields a frame-end
// transaction with signal_valid = !failsafe. A line error restarts the
// parser before its byte is handled; the failsafe flag survives it.
// Rate: one byte per cycle while in_full is low. The command for an accepted
// byte is written into the queue, and the unpacker then registers its result
// in the output register, from which it shows on the out_ ports.
// in_full rises only when the QUEUE_DEPTH-entry
// command queue between the position tracker and the bit unpacker is full,
// which happens when the result side stops popping.
// ----------------------------------------------------------------------------
module sbus_frame_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte transactions
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_received_byte,
  input  logic        in_line_error,
  // result transactions
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_result_kind,
  output logic [3:0]  out_channel_index,
  output logic [10:0] out_channel_value,
  output logic        out_signal_valid
);

  logic           q_full;
  logic           q_push;
  sbfd_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_pop;
  sbfd_pkg::cmd_t q_head;

  assign in_full = q_full;

  // position tracker: header hunt, data/flag/end classification
  sbfd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .q_full           (q_full),
    .in_received_byte (in_received_byte),
    .in_line_error    (in_line_error),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  // decouples byte intake from result backpressure
  sbfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // bit unpacker and output register
  sbfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_result_kind   (out_result_kind),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_signal_valid  (out_signal_valid)
  );

`ifndef SYNTHESIS
  // the front never pushes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // frame-end results carry zero index and value
  a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == sbfd_pkg::KIND_FRAME_END)
      |-> (out_channel_index == 4'd0 && out_channel_value == 11'd0))
    else $error("frame end with nonzero payload");

  // channel results never claim a valid signal
  a_channel_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == sbfd_pkg::KIND_CHANNEL) |-> !out_signal_valid)
    else $error("channel result with signal_valid set");

  // a result only appears after the unpacker took a command
  a_result_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(q_pop))
    else $error("result appeared without a command");
`endif

endmodule
